@@ design/sha256_pkg.sv @@
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_upper_mid;
    logic [63:0] digest_lower_mid;
    logic [63:0] digest_low;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMPRESS,
    ST_ADD,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    CORE_HOLD,
    CORE_INIT,
    CORE_LOAD,
    CORE_ROUND,
    CORE_ADD
  } core_op_t;

  // control for the block buffer / schedule line
  typedef struct packed {
    logic        shift;
    logic        wr_byte;
    logic        wr_len;
    logic [5:0]  pos;
    logic [7:0]  byte_val;
    logic [63:0] len_bits;
  } sched_ctl_t;

  localparam int unsigned ROUNDS = 64;
  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ design/sha256_message_hasher.sv @@
// SHA-256 hasher taking at most one message byte per request. Ordinary bytes are taken
// one per cycle; the byte that fills a 64-byte block starts a compression (64 rounds on
// the single round unit, then the hash update; the working variables load on the
// accepting edge). A request with last set pads one byte per cycle up to the length field
// (wrapping into a second block when fewer than 8 bytes remain after the 0x80 marker),
// then writes the length words, runs one or two block compressions, then places the
// 256-bit digest in the output register and restarts from the initial hash value.
// While busy, in_stall is high; a digest waiting on out_stall holds the block only
// when the next digest is ready to be written.
module sha256_message_hasher (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha256_pkg::in_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha256_pkg::out_t  out_data
);
  import sha256_pkg::*;

  state_t      state_r,  state_nxt;
  logic [5:0]  round_r,  round_nxt;
  logic [5:0]  fill_r,   fill_nxt;
  logic [60:0] len_r,    len_nxt;
  logic        pad_r,    pad_nxt;
  logic        marker_r, marker_nxt;
  logic        final_r,  final_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r;
  logic        out_load;
  sched_ctl_t  sctl;
  core_op_t    core_op;
  logic [31:0] sched_word;
  out_t        digest;

  sha256_sched u_sched (
    .clk      (clk),
    .ctl      (sctl),
    .word_out (sched_word)
  );

  sha256_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (core_op),
    .round_idx (round_r),
    .word_in   (sched_word),
    .digest    (digest)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    round_nxt     = round_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    pad_nxt       = pad_r;
    marker_nxt    = marker_r;
    final_nxt     = final_r;
    out_load      = 1'b0;
    core_op       = CORE_HOLD;
    sctl          = '0;
    sctl.pos      = fill_r;
    sctl.byte_val = in_data.data_byte;
    sctl.len_bits = {len_r, 3'b000};
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.has_byte) begin
            len_nxt      = len_r + 61'd1;
            sctl.wr_byte = 1'b1;
            fill_nxt     = fill_r + 6'd1;
            if (fill_r == LAST_POS) begin
              core_op    = CORE_LOAD;
              round_nxt  = '0;
              state_nxt  = ST_COMPRESS;
              pad_nxt    = in_data.last;
              marker_nxt = in_data.last;
            end else if (in_data.last) begin
              state_nxt  = ST_PAD;
              pad_nxt    = 1'b1;
              marker_nxt = 1'b1;
            end
          end else if (in_data.last) begin
            state_nxt  = ST_PAD;
            pad_nxt    = 1'b1;
            marker_nxt = 1'b1;
          end
        end
      end
      ST_PAD: begin
        if (!marker_r && fill_r == LEN_POS) begin
          sctl.wr_len = 1'b1;
          core_op     = CORE_LOAD;
          round_nxt   = '0;
          final_nxt   = 1'b1;
          state_nxt   = ST_COMPRESS;
        end else begin
          sctl.wr_byte  = 1'b1;
          sctl.byte_val = marker_r ? PAD_MARKER : 8'h00;
          marker_nxt    = 1'b0;
          fill_nxt      = fill_r + 6'd1;
          if (fill_r == LAST_POS) begin
            core_op   = CORE_LOAD;
            round_nxt = '0;
            state_nxt = ST_COMPRESS;
          end
        end
      end
      ST_COMPRESS: begin
        core_op    = CORE_ROUND;
        sctl.shift = 1'b1;
        round_nxt  = round_r + 6'd1;
        if (round_r == 6'(ROUNDS - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        core_op = CORE_ADD;
        if (final_r) begin
          state_nxt = ST_FINISH;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FINISH: begin
        // wait for the output register to be free, then restart the message
        if (!out_valid_r || !out_stall) begin
          out_load   = 1'b1;
          core_op    = CORE_INIT;
          fill_nxt   = '0;
          len_nxt    = '0;
          pad_nxt    = 1'b0;
          marker_nxt = 1'b0;
          final_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= '0;
      fill_r      <= '0;
      len_r       <= '0;
      pad_r       <= 1'b0;
      marker_r    <= 1'b0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_r     <= round_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      pad_r       <= pad_nxt;
      marker_r    <= marker_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= digest;
    end
  end

`ifndef SYNTHESIS
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPRESS && round_r == 6'(ROUNDS - 1)) |=> state_r == ST_ADD)
    else $error("compression did not end after the last round");

  a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("digest presented without a final compression");

  a_idle_no_pad: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pad_r && !final_r)
    else $error("padding left pending while idle");

  a_len_field_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAD && $past(state_r) == ST_PAD && $past(fill_r) == LEN_POS
      && !$past(marker_r)) |-> 1'b0)
    else $error("padding continued past the length field");
`endif

endmodule

@@ design/sha256_sched.sv @@
module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctl_t ctl,
  output logic [31:0]            word_out
);
  import sha256_pkg::*;

  logic [31:0] w_r   [16];
  logic [31:0] w_nxt [16];
  logic [31:0] next_word;
  logic [3:0]  word_idx;
  logic [1:0]  lane;

  assign word_idx = ctl.pos[5:2];
  assign lane     = ctl.pos[1:0];
  // appended word is W[t+16] while the window holds W[t..t+15]
  assign next_word = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];
  assign word_out  = w_r[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_nxt[i] = w_r[i];
    end
    if (ctl.shift) begin
      for (int i = 0; i < 15; i++) begin
        w_nxt[i] = w_r[i + 1];
      end
      w_nxt[15] = next_word;
    end else begin
      if (ctl.wr_byte) begin
        // first byte of a word clears the rest of it
        if (lane == 2'd0) begin
          w_nxt[word_idx] = {ctl.byte_val, 24'h0};
        end else begin
          w_nxt[word_idx][{~lane, 3'b000} +: 8] = ctl.byte_val;
        end
      end
      if (ctl.wr_len) begin
        w_nxt[14] = ctl.len_bits[63:32];
        w_nxt[15] = ctl.len_bits[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) begin
      w_r[i] <= w_nxt[i];
    end
  end

endmodule

@@ design/sha256_core.sv @@
module sha256_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::core_op_t op,
  input  logic [5:0]           round_idx,
  input  logic [31:0]          word_in,
  output sha256_pkg::out_t     digest
);
  import sha256_pkg::*;

  logic [31:0] hash_r    [8];
  logic [31:0] hash_nxt  [8];
  logic [31:0] work_r    [8];
  logic [31:0] work_nxt  [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch_val;
  logic [31:0] maj_val;

  assign ch_val  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
  assign maj_val = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
  assign t1 = work_r[7] + big_sigma1(work_r[4]) + ch_val + ROUND_K[round_idx] + word_in;
  assign t2 = big_sigma0(work_r[0]) + maj_val;

  assign digest.digest_high      = {hash_r[0], hash_r[1]};
  assign digest.digest_upper_mid = {hash_r[2], hash_r[3]};
  assign digest.digest_lower_mid = {hash_r[4], hash_r[5]};
  assign digest.digest_low       = {hash_r[6], hash_r[7]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_nxt[i] = hash_r[i];
      work_nxt[i] = work_r[i];
    end
    case (op)
      CORE_HOLD: begin
      end
      CORE_INIT: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = INIT_HASH[i];
        end
      end
      CORE_LOAD: begin
        for (int i = 0; i < 8; i++) begin
          work_nxt[i] = hash_r[i];
        end
      end
      CORE_ROUND: begin
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
      end
      CORE_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + work_r[i];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= INIT_HASH[i];
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 8; i++) begin
      work_r[i] <= work_nxt[i];
    end
  end

endmodule
